### rtl/slm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slm_pkg
// shared constants, trig and window tables, state and command types for the
// stft log-magnitude block
// ---------------------------------------------------------------------------
package slm_pkg;

  localparam int FFT_SIZE = 128;
  localparam int NUM_BINS = FFT_SIZE / 2;
  localparam int IDX_W    = $clog2(FFT_SIZE);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int SEEN_W   = $clog2(FFT_SIZE + 1);
  localparam int SAMPLE_W = 16;
  localparam int HOP_W    = 8;
  localparam int LEVEL_W  = 17;
  localparam int TRIG_W   = 17;
  localparam int WIN_W    = 17;
  localparam int ACC_W    = 48;
  localparam int LOGV_W   = 48;
  localparam int CNT_W    = 5;

  localparam logic [HOP_W-1:0] HOP_RESET = 8'd64;

  // log2 of the frame size plus the q30 scale of the sums
  localparam int LOG_OFS = IDX_W + 30;
  // epsilon floor added to the magnitude, in q30 sum units
  localparam int FLOOR_ADD = FFT_SIZE * 128;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [27:0] DB_PER_OCT_Q24 = 28'sd101008905;
  localparam logic signed [LEVEL_W-1:0] DB_FLOOR = -17'sd35456;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_NORM,
    ST_SUM,
    ST_SQRT,
    ST_LOGLD,
    ST_LOGN,
    ST_FRAC,
    ST_DBMUL,
    ST_DBOUT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             smp_write;
    logic             mac_clear;
    logic             mac_issue;
    logic [IDX_W-1:0] mac_idx;
    logic [BIN_W-1:0] bin;
    logic             norm_load;
    logic             norm_step;
    logic             square;
    logic             sum;
    logic             sqrt_step;
    logic             log_load;
    logic             log_step;
    logic             frac_init;
    logic             frac_step;
    logic             db_mul;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic norm_ok;
    logic log_ok;
  } status_t;

  typedef logic [FFT_SIZE-1:0][TRIG_W-1:0] trig_tab_t;
  typedef logic [FFT_SIZE-1:0][WIN_W-1:0]  win_tab_t;

  // sin(pi/2 * q / FFT_SIZE) in q30, integer series
  function automatic longint trig_q30(input longint unsigned q);
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    quad = (q / FFT_SIZE) & 64'd3;
    r    = q % FFT_SIZE;
    if (quad[0]) t = ((FFT_SIZE - r) << 30) / FFT_SIZE;
    else         t = (r << 30) / FFT_SIZE;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    term = Q30_ONE - ((x2 * term) >> 30) / 110;
    term = Q30_ONE - ((x2 * term) >> 30) / 72;
    term = Q30_ONE - ((x2 * term) >> 30) / 42;
    term = Q30_ONE - ((x2 * term) >> 30) / 20;
    term = Q30_ONE - ((x2 * term) >> 30) / 6;
    s    = (x * term) >> 30;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // divide by 2^sh, round half away from zero
  function automatic longint round_shift(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic trig_tab_t make_cos_tab();
    trig_tab_t tab;
    for (int m = 0; m < FFT_SIZE; m++) begin
      tab[m] = TRIG_W'(round_shift(trig_q30(longint'(4 * m + FFT_SIZE)), 15));
    end
    return tab;
  endfunction

  function automatic trig_tab_t make_sin_tab();
    trig_tab_t tab;
    for (int m = 0; m < FFT_SIZE; m++) begin
      tab[m] = TRIG_W'(round_shift(trig_q30(longint'(4 * m)), 15));
    end
    return tab;
  endfunction

  function automatic win_tab_t make_win_tab();
    win_tab_t tab;
    longint   c30;
    for (int m = 0; m < FFT_SIZE; m++) begin
      c30    = trig_q30(longint'(4 * m + FFT_SIZE));
      tab[m] = WIN_W'((longint'(longint'(Q30_ONE) - c30) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = make_cos_tab();
  localparam trig_tab_t SIN_TAB = make_sin_tab();
  localparam win_tab_t  WIN_TAB = make_win_tab();

endpackage
`default_nettype wire

### rtl/slm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slm_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/slm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slm_datapath
// sample ring buffer, windowed dft mac pipeline, magnitude, log2 and db units
// ---------------------------------------------------------------------------
module slm_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  slm_pkg::cmd_t                        cmd,
  output slm_pkg::status_t                     status,
  input  logic [slm_pkg::SAMPLE_W-1:0]         sample,
  output logic [slm_pkg::BIN_W-1:0]            bin_index,
  output logic signed [slm_pkg::LEVEL_W-1:0]   level_db,
  output logic                                 frame_last
);

  localparam int IW = slm_pkg::IDX_W;
  localparam int AW = slm_pkg::ACC_W;
  localparam int VW = slm_pkg::LOGV_W;

  // sample ring, wptr is the oldest entry after each write
  logic [IW-1:0]                wptr;
  logic [IW-1:0]                raddr;
  logic [slm_pkg::SAMPLE_W-1:0] ram_rdata;

  // mac pipeline
  logic [2*IW-1:0]     mprod;
  logic                v1, v2, v3;
  logic [IW-1:0]       i1, m1, m2;
  logic signed [33:0]  wprod;
  logic [33:0]         wmag;
  logic [33:0]         wrnd;
  logic signed [17:0]  xw;
  logic signed [34:0]  re_p, im_p;
  logic signed [AW-1:0] acc_re, acc_im;

  // magnitude
  logic [AW-1:0] ar, ai;
  logic [3:0]    sh;
  logic [61:0]   sq_r, sq_i;
  logic [62:0]   rem, res, sbit, trial;

  // log2 and db
  logic [VW-1:0]       lv;
  logic [5:0]          lp;
  logic [30:0]         y;
  logic [61:0]         yy;
  logic [19:0]         frac;
  logic signed [6:0]   pm;
  logic signed [26:0]  d;
  logic signed [54:0]  dprod;
  logic [54:0]         dmag;
  logic [54:0]         drnd;
  logic signed [19:0]  db;

  assign raddr = wptr + cmd.mac_idx;
  assign mprod = (2*IW)'(cmd.bin) * (2*IW)'(cmd.mac_idx);

  slm_ram #(
    .WIDTH(slm_pkg::SAMPLE_W),
    .DEPTH(slm_pkg::FFT_SIZE)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.smp_write),
    .waddr(wptr),
    .wdata(sample),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      if (cmd.smp_write) begin
        wptr <= wptr + 1'b1;
      end
      v1 <= cmd.mac_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // window rounding, half away from zero
  always_comb begin
    wmag = wprod[33] ? 34'(-wprod) : 34'(wprod);
    wrnd = (wmag + 34'(1 << 14)) >> 15;
    xw   = wprod[33] ? -$signed(18'(wrnd)) : $signed(18'(wrnd));
  end

  always_ff @(posedge clk) begin
    i1    <= cmd.mac_idx;
    m1    <= mprod[IW-1:0];
    wprod <= $signed(ram_rdata) * $signed({1'b0, slm_pkg::WIN_TAB[i1]});
    m2    <= m1;
    re_p  <= xw * $signed(slm_pkg::COS_TAB[m2]);
    im_p  <= xw * $signed(slm_pkg::SIN_TAB[m2]);
    if (cmd.mac_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v3) begin
      acc_re <= acc_re + AW'(re_p);
      acc_im <= acc_im - AW'(im_p);
    end
  end

  assign trial = res + sbit;
  assign yy    = 62'(y) * 62'(y);
  assign pm    = $signed(7'(lp)) - 7'(slm_pkg::LOG_OFS);
  assign d     = {pm, frac};

  // db rounding, half away from zero; the clamp is applied at out_load
  always_comb begin
    dmag = dprod[54] ? 55'(-dprod) : 55'(dprod);
    drnd = (dmag + (55'd1 << 35)) >> 36;
    db   = dprod[54] ? -$signed(20'(drnd)) : $signed(20'(drnd));
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      ar <= acc_re[AW-1] ? AW'(-acc_re) : AW'(acc_re);
      ai <= acc_im[AW-1] ? AW'(-acc_im) : AW'(acc_im);
      sh <= '0;
    end else if (cmd.norm_step) begin
      ar <= ar >> 1;
      ai <= ai >> 1;
      sh <= sh + 1'b1;
    end
    if (cmd.square) begin
      sq_r <= 62'(ar[30:0]) * 62'(ar[30:0]);
      sq_i <= 62'(ai[30:0]) * 62'(ai[30:0]);
    end
    if (cmd.sum) begin
      rem  <= 63'(sq_r) + 63'(sq_i);
      res  <= '0;
      sbit <= {1'b1, 62'b0};
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.log_load) begin
      lv <= (VW'(res[31:0]) << sh) + VW'(slm_pkg::FLOOR_ADD);
      lp <= 6'(VW - 1);
    end else if (cmd.log_step) begin
      lv <= lv << 1;
      lp <= lp - 1'b1;
    end
    if (cmd.frac_init) begin
      y    <= lv[VW-1:VW-31];
      frac <= '0;
    end else if (cmd.frac_step) begin
      if (yy[61]) begin
        y    <= yy[61:31];
        frac <= {frac[18:0], 1'b1};
      end else begin
        y    <= yy[60:30];
        frac <= {frac[18:0], 1'b0};
      end
    end
    if (cmd.db_mul) begin
      dprod <= d * slm_pkg::DB_PER_OCT_Q24;
    end
    if (cmd.out_load) begin
      bin_index  <= cmd.bin;
      frame_last <= (cmd.bin == slm_pkg::BIN_W'(slm_pkg::NUM_BINS - 1));
      if (db > 20'sd0) begin
        level_db <= '0;
      end else if (db < 20'(slm_pkg::DB_FLOOR)) begin
        level_db <= slm_pkg::DB_FLOOR;
      end else begin
        level_db <= db[slm_pkg::LEVEL_W-1:0];
      end
    end
  end

  assign status.mac_busy = v1 | v2 | v3;
  assign status.norm_ok  = ((ar[AW-1:31] | ai[AW-1:31]) == '0);
  assign status.log_ok   = lv[VW-1];

endmodule
`default_nettype wire

### rtl/slm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slm_ctrl
// frame scheduling (warm-up and hop) and sequencing of the per-bin work
// ---------------------------------------------------------------------------
module slm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slm_pkg::HOP_W-1:0]     cfg_data,
  input  logic                          s_valid,
  output logic                          s_ready,
  output logic                          m_valid,
  input  logic                          m_ready,
  output slm_pkg::cmd_t                 cmd,
  input  slm_pkg::status_t              status
);

  localparam int HW = slm_pkg::HOP_W;
  localparam int SW = slm_pkg::SEEN_W;

  slm_pkg::state_t state, state_next;

  logic [HW-1:0]            hop_size;
  logic [SW-1:0]            seen, seen_next;
  logic [HW-1:0]            hop_count, hop_count_next;
  logic [slm_pkg::BIN_W-1:0] bin, bin_next;
  logic [slm_pkg::IDX_W-1:0] idx, idx_next;
  logic [slm_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [HW:0]              hop_inc;
  logic [HW-1:0]            hop_eff;
  logic                     frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slm_pkg::ST_IDLE;
      hop_size  <= slm_pkg::HOP_RESET;
      seen      <= '0;
      hop_count <= '0;
      bin       <= '0;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      seen      <= seen_next;
      hop_count <= hop_count_next;
      bin       <= bin_next;
      idx       <= idx_next;
      cnt       <= cnt_next;
      if (cfg_we) begin
        hop_size <= cfg_data;
      end
    end
  end

  // frame decision for an incoming sample
  always_comb begin
    hop_inc        = (HW+1)'(hop_count) + 1'b1;
    hop_eff        = (hop_size == '0) ? HW'(1) : hop_size;
    frame          = 1'b0;
    seen_next      = seen;
    hop_count_next = hop_count;
    if (s_valid && s_ready) begin
      if (seen < SW'(slm_pkg::FFT_SIZE)) begin
        seen_next = seen + 1'b1;
        if (seen_next == SW'(slm_pkg::FFT_SIZE)) begin
          frame          = 1'b1;
          hop_count_next = '0;
        end
      end else if (hop_inc >= (HW+1)'(hop_eff)) begin
        frame          = 1'b1;
        hop_count_next = '0;
      end else begin
        hop_count_next = hop_inc[HW-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    bin_next   = bin;
    idx_next   = idx;
    cnt_next   = cnt;
    s_ready    = 1'b0;
    m_valid    = 1'b0;
    cmd        = '0;
    cmd.bin    = bin;
    cmd.mac_idx = idx;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        s_ready       = 1'b1;
        cmd.mac_clear = 1'b1;
        cmd.smp_write = s_valid;
        if (frame) begin
          bin_next   = '0;
          idx_next   = '0;
          state_next = slm_pkg::ST_MAC;
        end
      end
      slm_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        idx_next      = idx + 1'b1;
        if (idx == slm_pkg::IDX_W'(slm_pkg::FFT_SIZE - 1)) begin
          state_next = slm_pkg::ST_DRAIN;
        end
      end
      slm_pkg::ST_DRAIN: begin
        if (!status.mac_busy) begin
          cmd.norm_load = 1'b1;
          state_next    = slm_pkg::ST_NORM;
        end
      end
      slm_pkg::ST_NORM: begin
        if (status.norm_ok) begin
          cmd.square = 1'b1;
          state_next = slm_pkg::ST_SUM;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      slm_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = slm_pkg::ST_SQRT;
      end
      slm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = slm_pkg::ST_LOGLD;
        end
      end
      slm_pkg::ST_LOGLD: begin
        cmd.log_load = 1'b1;
        state_next   = slm_pkg::ST_LOGN;
      end
      slm_pkg::ST_LOGN: begin
        if (status.log_ok) begin
          cmd.frac_init = 1'b1;
          cnt_next      = '0;
          state_next    = slm_pkg::ST_FRAC;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      slm_pkg::ST_FRAC: begin
        cmd.frac_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == slm_pkg::CNT_W'(19)) begin
          state_next = slm_pkg::ST_DBMUL;
        end
      end
      slm_pkg::ST_DBMUL: begin
        cmd.db_mul = 1'b1;
        state_next = slm_pkg::ST_DBOUT;
      end
      slm_pkg::ST_DBOUT: begin
        cmd.out_load = 1'b1;
        state_next   = slm_pkg::ST_OUT;
      end
      slm_pkg::ST_OUT: begin
        m_valid = 1'b1;
        if (m_ready) begin
          cmd.mac_clear = 1'b1;
          idx_next      = '0;
          if (bin == slm_pkg::BIN_W'(slm_pkg::NUM_BINS - 1)) begin
            state_next = slm_pkg::ST_IDLE;
          end else begin
            bin_next   = bin + 1'b1;
            state_next = slm_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_next = slm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/stft_log_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stft_log_magnitude
// hann-windowed 128-point short-time spectrum, 64 bins out in q8.8 db
// ---------------------------------------------------------------------------
// Samples (signed q1.15) stream in on the slave side; the last 128 are kept in
// a ring buffer ram. After the first 128 samples, and then every hop_size
// samples (0 acts as 1), a frame is computed and bins 0..63 leave on the
// master side in order, tlast on bin 63, each as 20*log10(|X|/128 + 2^-23)
// in signed q8.8 clamped to [-35456, 0]. A sample that starts no frame leaves
// the input ready. A frame keeps the input stalled while each bin runs through
// the one window/dft mac pipeline (a window, a cos and a sin multiplier),
// then a serial magnitude unit (up to 7 normalize steps, 32 square-root
// steps, up to 33 log normalize steps, 20 log fraction steps) plus the
// output transfer. hop_size is written through cfg_we/cfg_data; the user
// must write it only while the block is idle, the block does not enforce it.
module stft_log_magnitude (
  input  logic        clk,
  input  logic        rst,
  // configuration: hop_size
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  // bin output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] bin_index, [22:6] level_db, [23] zero
  output logic        m_axis_tlast    // frame_last
);

  slm_pkg::cmd_t    cmd;
  slm_pkg::status_t status;

  logic [slm_pkg::BIN_W-1:0]          bin_index;
  logic signed [slm_pkg::LEVEL_W-1:0] level_db;
  logic                               frame_last;

  // scheduling and sequencing
  slm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .status  (status)
  );

  // sample store, dft and level math; output fields are registered here
  slm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_axis_tdata),
    .bin_index (bin_index),
    .level_db  (level_db),
    .frame_last(frame_last)
  );

  // pack the result transfer, padding bit stays zero
  assign m_axis_tdata = {1'b0, level_db, bin_index};
  assign m_axis_tlast = frame_last;

endmodule
`default_nettype wire

### rtl/slm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slm_checker
// port-level checks for the stft log-magnitude block
// ---------------------------------------------------------------------------
module slm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // input is only taken while no result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is shown");

  // level never above 0 db
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[22] || (m_axis_tdata[22:6] == 17'd0))
    else $error("positive level");

  // tlast marks exactly the top bin
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:0] == 6'd63)))
    else $error("tlast does not match bin 63");

endmodule

bind stft_log_magnitude slm_checker u_slm_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
